// ===== design/u16to8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16to8_pkg
// Shared types, constants and the code point encoder for the transcoder.
// ----------------------------------------------------------------------------
package u16to8_pkg;

  localparam int RUN_MAX   = 6;
  localparam int LEN_W     = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] LIM_1BYTE  = 21'h80;
  localparam logic [20:0] LIM_2BYTE  = 21'h800;
  localparam logic [20:0] LIM_3BYTE  = 21'h10000;
  localparam logic [5:0]  HIGH_TAG   = 6'b110110;

  typedef struct packed {
    logic [3:0][7:0]  bytes;
    logic [LEN_W-1:0] len;
  } point_enc_t;

  // one request's whole byte run; byte 0 goes out first
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [LEN_W-1:0]        len;
  } run_t;

  function automatic point_enc_t encode_point(input logic [20:0] c);
    point_enc_t r;
    r.bytes = '0;
    if (c < LIM_1BYTE) begin
      r.bytes[0] = {1'b0, c[6:0]};
      r.len      = 3'd1;
    end else if (c < LIM_2BYTE) begin
      r.bytes[0] = {3'b110, c[10:6]};
      r.bytes[1] = {2'b10, c[5:0]};
      r.len      = 3'd2;
    end else if (c < LIM_3BYTE) begin
      r.bytes[0] = {4'b1110, c[15:12]};
      r.bytes[1] = {2'b10, c[11:6]};
      r.bytes[2] = {2'b10, c[5:0]};
      r.len      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, c[20:18]};
      r.bytes[1] = {2'b10, c[17:12]};
      r.bytes[2] = {2'b10, c[11:6]};
      r.bytes[3] = {2'b10, c[5:0]};
      r.len      = 3'd4;
    end
    return r;
  endfunction

endpackage

// ===== design/u16to8_if.sv =====
// ----------------------------------------------------------------------------
// u16to8 channel interfaces
// Valid/ready channels for UTF-16 code units in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
interface u16to8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_string;

  modport source (output valid, output code_unit, output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface u16to8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       last_of_run;

  modport source (output valid, output utf8_byte, output last_of_run, input ready);
  modport sink   (input valid, input utf8_byte, input last_of_run, output ready);
endinterface

// ===== design/u16to8_front.sv =====
// ----------------------------------------------------------------------------
// u16to8_front
// Accepts code units, pairs surrogates and builds each request's byte run.
// ----------------------------------------------------------------------------
module u16to8_front
  import u16to8_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  u16to8_in_if.sink    unit_ch,
  input  logic         q_full,
  output logic         push_valid,
  output run_t         push_run
);

  logic       pending;
  logic       pending_next;
  logic [9:0] held;
  logic [9:0] held_next;

  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       pair;
  logic       hold;
  logic       pre_valid;
  logic [20:0] pair_point;
  point_enc_t pre_enc;
  point_enc_t main_enc;
  run_t       run;

  assign unit_ch.ready = !q_full;
  assign accept        = unit_ch.valid && unit_ch.ready;

  always_comb begin
    is_high    = unit_ch.code_unit inside {[HIGH_FIRST:HIGH_LAST]};
    is_low     = unit_ch.code_unit inside {[LOW_FIRST:LOW_LAST]};
    pair       = pending && is_low;
    pre_valid  = pending && !is_low;
    hold       = !pair && is_high && !unit_ch.end_of_string;
    pair_point = SUPP_BASE + {1'b0, held, unit_ch.code_unit[9:0]};
    pre_enc    = encode_point({5'b0, HIGH_TAG, held});
    if (pair) begin
      main_enc = encode_point(pair_point);
    end else if (hold) begin
      main_enc = '0;
    end else begin
      main_enc = encode_point({5'b0, unit_ch.code_unit});
    end
    run = '0;
    if (pre_valid) begin
      run.bytes[2:0] = pre_enc.bytes[2:0];
      run.bytes[5:3] = main_enc.bytes[2:0];
      run.len        = pre_enc.len + main_enc.len;
    end else begin
      run.bytes[3:0] = main_enc.bytes;
      run.len        = main_enc.len;
    end
  end

  always_comb begin
    pending_next = pending;
    held_next    = held;
    if (accept) begin
      pending_next = hold;
      if (hold) begin
        held_next = unit_ch.code_unit[9:0];
      end
    end
  end

  assign push_valid = accept && (run.len != '0);
  assign push_run   = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      held    <= '0;
    end else begin
      pending <= pending_next;
      held    <= held_next;
    end
  end

endmodule

// ===== design/u16to8_queue.sv =====
// ----------------------------------------------------------------------------
// u16to8_queue
// Short queue of byte runs between the front and the serializer.
// ----------------------------------------------------------------------------
module u16to8_queue
  import u16to8_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  run_t  push_run,
  input  logic  pop,
  output logic  q_full,
  output logic  q_empty,
  output run_t  head
);

  run_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign q_full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_push = push_valid && !q_full;
  assign do_pop  = pop && !q_empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/u16to8_back.sv =====
// ----------------------------------------------------------------------------
// u16to8_back
// Sends the head run of the queue one byte per cycle while byte_ch.ready is high.
// ----------------------------------------------------------------------------
module u16to8_back
  import u16to8_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  run_t          head,
  output logic          pop,
  u16to8_out_if.source  byte_ch
);

  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] idx_next;
  logic             last;
  logic             fire;

  assign last                = (idx == head.len - 1'b1);
  assign byte_ch.valid       = !q_empty;
  assign byte_ch.utf8_byte   = head.bytes[idx];
  assign byte_ch.last_of_run = last;
  assign fire                = byte_ch.valid && byte_ch.ready;
  assign pop                 = fire && last;

  always_comb begin
    idx_next = idx;
    if (fire) begin
      idx_next = last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

endmodule

// ===== design/utf16_to_utf8_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 code units in, UTF-8 bytes out.
// ----------------------------------------------------------------------------
// unit_ch takes one code unit per request with end_of_string on the last unit
// of a string; byte_ch returns one UTF-8 byte per request, last_of_run on the
// final byte a unit caused. A high surrogate without end_of_string is held with
// no output until the next unit; units that produce no bytes leave nothing on
// byte_ch. The front classifies and encodes a unit in the cycle it is accepted
// and writes its run into a 4-entry queue; if the queue was empty, the first
// byte is offered on the next cycle. The serializer drains one byte per cycle
// while byte_ch.ready is high. A run holds 1 to 3 bytes for a basic-plane unit,
// 4 for a pair, up to 6 for a flushed surrogate followed by another unit.
// unit_ch accepts back to back while the queue has room, also while byte_ch is
// stalled; a stalled byte holds and the queue fills, then unit_ch.ready drops.
// Reset clears the held surrogate, the queue and the byte index.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top
  import u16to8_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  u16to8_in_if.sink    unit_ch,
  u16to8_out_if.source byte_ch
);

  logic push_valid;
  run_t push_run;
  logic pop;
  logic q_full;
  logic q_empty;
  run_t head;

  u16to8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_ch    (unit_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_run   (push_run)
  );

  u16to8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_run   (push_run),
    .pop        (pop),
    .q_full     (q_full),
    .q_empty    (q_empty),
    .head       (head)
  );

  u16to8_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .byte_ch (byte_ch)
  );

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |-> (byte_ch.valid && byte_ch.ready && byte_ch.last_of_run))
    else $error("queue popped without the last byte of a run");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push_valid && q_empty) |=> byte_ch.valid)
    else $error("pushed run not offered on the next cycle");

  a_head_len: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (head.len != '0 && head.len <= 3'(RUN_MAX)))
    else $error("queued run has a bad length");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push_valid)
    else $error("run pushed into a full queue");

endmodule

// ===== tb/utf16_to_utf8_transcoder_top_test.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top_test
// Streams UTF-16 strings into the transcoder with bursty requests and a
// stalling byte sink, predicts each UTF-8 byte and last_of_run flag, and
// checks the byte stream in order.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top_test;
  import u16to8_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_UNITS = 420;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } unit_req_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_run;
  } utf8_byte_t;

  logic clk;
  logic rst;

  u16to8_in_if  unit_ch ();
  u16to8_out_if byte_ch ();

  utf16_to_utf8_transcoder_top DUT (
    .clk     (clk),
    .rst     (rst),
    .unit_ch (unit_ch),
    .byte_ch (byte_ch)
  );

  unit_req_t  unit_reqs[$];
  utf8_byte_t utf8_expected[$];

  int units_planned  = 0;
  int units_accepted = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  // predictor state
  logic       high_held = 1'b0;
  logic [9:0] held_bits = '0;

  // sender / receiver pacing
  logic        unit_taken     = 1'b0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  int          stall_seg_left = 0;
  logic [15:0] stall_pattern  = '1;
  logic        next_valid;
  unit_req_t   next_req;
  utf8_byte_t  got_byte;
  utf8_byte_t  want_byte;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic add_unit(input logic [15:0] cu, input logic eos);
    unit_req_t r;
    r.code_unit     = cu;
    r.end_of_string = eos;
    unit_reqs.push_back(r);
    units_planned++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    utf8_byte_t e;
    e.utf8_byte   = b;
    e.last_of_run = 1'b0;
    utf8_expected.push_back(e);
  endtask

  task automatic encode_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_byte({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      push_byte({3'b110, cp[10:6]});
      push_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end else begin
      push_byte({5'b11110, cp[20:18]});
      push_byte({2'b10, cp[17:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic transcode_unit(input logic [15:0] cu, input logic eos);
    int         start_size;
    logic       paired;
    utf8_byte_t tail;
    start_size = utf8_expected.size();
    paired = 1'b0;
    if (high_held) begin
      high_held = 1'b0;
      if (cu >= LOW_FIRST && cu <= LOW_LAST) begin
        encode_code_point(21'h10000 + {held_bits, 10'b0} + (cu - LOW_FIRST));
        paired = 1'b1;
      end else begin
        encode_code_point({5'b0, HIGH_TAG, held_bits});
      end
      held_bits = '0;
    end
    if (!paired) begin
      if (cu >= HIGH_FIRST && cu <= HIGH_LAST && !eos) begin
        high_held = 1'b1;
        held_bits = cu[9:0];
      end else begin
        encode_code_point({5'b0, cu});
      end
    end
    if (utf8_expected.size() > start_size) begin
      tail = utf8_expected.pop_back();
      tail.last_of_run = 1'b1;
      utf8_expected.push_back(tail);
    end
  endtask

  task automatic build_strings();
    int          str_len;
    int          pick;
    logic        at_end;
    logic        stray_eos;
    logic [15:0] cu;
    while (units_planned < RANDOM_UNITS + 24) begin
      str_len = $urandom_range(1, 12);
      for (int k = 0; k < str_len; k++) begin
        at_end    = (k == str_len - 1);
        stray_eos = ($urandom_range(0, 15) == 0);
        pick      = $urandom_range(0, 99);
        if (pick < 18) begin
          cu = 16'($urandom_range(16'h0000, 16'h007F));
        end else if (pick < 32) begin
          cu = 16'($urandom_range(16'h0080, 16'h07FF));
        end else if (pick < 46) begin
          cu = 16'($urandom_range(16'h0800, 16'hD7FF));
        end else if (pick < 54) begin
          cu = 16'($urandom_range(16'hE000, 16'hFFFF));
        end else if (pick < 78) begin
          add_unit(HIGH_FIRST + 16'($urandom_range(0, 1023)), stray_eos);
          cu = LOW_FIRST + 16'($urandom_range(0, 1023));
        end else if (pick < 86) begin
          cu = HIGH_FIRST + 16'($urandom_range(0, 1023));
        end else if (pick < 92) begin
          cu = LOW_FIRST + 16'($urandom_range(0, 1023));
        end else begin
          cu = 16'($urandom);
        end
        add_unit(cu, at_end || stray_eos);
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    rst                   = 1'b1;
    unit_ch.valid         = 1'b0;
    unit_ch.code_unit     = '0;
    unit_ch.end_of_string = 1'b0;
    byte_ch.ready         = 1'b0;

    add_unit(16'h0000, 1'b0);
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07FF, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hD7FF, 1'b0);
    add_unit(16'hE000, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    add_unit(16'hD800, 1'b0);
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hDFFF, 1'b0);
    add_unit(16'hD83D, 1'b0);
    add_unit(16'hDE00, 1'b1);
    add_unit(16'hDBFF, 1'b1);
    add_unit(16'hD800, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_unit(16'hDA00, 1'b0);
    add_unit(16'hDB00, 1'b0);
    add_unit(16'h0041, 1'b1);
    add_unit(16'hD900, 1'b0);
    add_unit(16'hDBFF, 1'b1);
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDFFF, 1'b1);
    build_strings();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (units_accepted < units_planned || utf8_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("utf16_to_utf8_transcoder_top verification clean");
    end else begin
      $display("utf16_to_utf8_transcoder_top verification failed");
    end
    $finish;
  end

  // request driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      unit_ch.valid <= 1'b0;
    end else begin
      next_valid = unit_ch.valid;
      next_req   = {unit_ch.code_unit, unit_ch.end_of_string};
      if (!unit_ch.valid || unit_taken) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (unit_reqs.size() != 0) begin
          next_req   = unit_reqs.pop_front();
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      unit_ch.valid         <= next_valid;
      unit_ch.code_unit     <= next_req.code_unit;
      unit_ch.end_of_string <= next_req.end_of_string;
    end
  end

  // byte sink: rotating stall pattern, re-rolled per segment
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.ready <= 1'b0;
    end else begin
      if (stall_seg_left == 0) begin
        stall_seg_left = $urandom_range(16, 160);
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = 16'($urandom) | 16'h0001;
          2: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
          default: stall_pattern = 16'($urandom | $urandom);
        endcase
      end else begin
        stall_seg_left--;
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      byte_ch.ready <= stall_pattern[0];
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) begin
        got_byte = {byte_ch.utf8_byte, byte_ch.last_of_run};
        if (utf8_expected.size() == 0) begin
          error_count++;
          $display("%0t: unexpected byte: expected none, actual byte=%02h last=%0b",
                   $time, got_byte.utf8_byte, got_byte.last_of_run);
        end else begin
          want_byte = utf8_expected.pop_front();
          if (got_byte.utf8_byte !== want_byte.utf8_byte) begin
            error_count++;
            $display("%0t: utf8_byte mismatch: expected %02h, actual %02h",
                     $time, want_byte.utf8_byte, got_byte.utf8_byte);
          end
          if (got_byte.last_of_run !== want_byte.last_of_run) begin
            error_count++;
            $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                     $time, want_byte.last_of_run, got_byte.last_of_run);
          end
        end
      end
      if (unit_ch.valid && unit_ch.ready) begin
        transcode_unit(unit_ch.code_unit, unit_ch.end_of_string);
        units_accepted++;
      end
    end
    unit_taken = !rst && unit_ch.valid && unit_ch.ready;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("utf16_to_utf8_transcoder_top verification failed");
      $finish;
    end
  end

endmodule
